@@ rtl/core/s2c_pkg.sv @@
// Package with constants, types, the CORDIC step function and the saturation function for the spherical converter.
package s2c_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                                     CORDIC_ITERATIONS : ATAN_ENTRIES;

  localparam int CW = 34;

  localparam logic signed [15:0]   THETA_LO    = 16'sd205;
  localparam logic signed [15:0]   THETA_HI    = 16'sd12663;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

  typedef struct packed {
    rot_t               th;
    rot_t               ph;
    logic               neg_ct;
    logic [1:0]         quad;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] rho;
  } cstage_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } sat_t;

  function automatic rot_t cordic_step(rot_t s, int i);
    rot_t                 r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    dx = s.x >>> i;
    dy = s.y >>> i;
    at = $signed({2'b00, ATAN_Q30[i[4:0]]});
    if (!s.z[CW-1]) begin
      r.x = s.x - dy;
      r.y = s.y + dx;
      r.z = s.z - at;
    end else begin
      r.x = s.x + dy;
      r.y = s.y - dx;
      r.z = s.z + at;
    end
    return r;
  endfunction

  function automatic sat_t saturate(logic signed [40:0] v);
    sat_t r;
    if (v > 41'sd2147483647) begin
      r.value = 32'h7FFF_FFFF;
      r.sat   = 1'b1;
    end else if (v < -41'sd2147483648) begin
      r.value = 32'h8000_0000;
      r.sat   = 1'b1;
    end else begin
      r.value = v[31:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/spherical_to_cartesian_offset.sv @@
// Pipelined spherical to Cartesian converter with origin offset, y axis up.
// The pipeline has one stage per CORDIC step,
// plus the input, product, rounding, projection and output stages.
// Throughput is one transfer per cycle; busy_o is always low and the receiver cannot stall.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
module spherical_to_cartesian_offset
  import s2c_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] radius_i,
  input  logic signed [15:0] polar_angle_i,
  input  logic        [15:0] azimuth_angle_i,
  output logic               done_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic               saturated_o
);

  localparam int NSTAGES = CORDIC_STEPS + 5;
  localparam logic signed [65:0] RND66 = 66'sd536870912;
  localparam logic signed [69:0] RND70 = 70'sd536870912;

  logic [NSTAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTAGES-2:0], start_i};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[NSTAGES-1];

  // Input stage: clamp and fold the polar angle, scale the azimuth.
  logic signed [15:0]   th_c;
  logic signed [CW-1:0] th_a;
  logic signed [CW-1:0] za_d;
  logic                 neg_d;
  logic        [45:0]   phi_prod_d;

  always_comb begin
    if (polar_angle_i < THETA_LO) begin
      th_c = THETA_LO;
    end else if (polar_angle_i > THETA_HI) begin
      th_c = THETA_HI;
    end else begin
      th_c = polar_angle_i;
    end
    th_a  = {{(CW-16){th_c[15]}}, th_c} <<< 18;
    neg_d = th_a > HALF_PI_Q30;
    za_d  = neg_d ? (PI_Q30 - th_a) : th_a;
    phi_prod_d = 46'(azimuth_angle_i[13:0]) * 46'(HALF_PI_Q30[30:0]);
  end

  logic signed [CW-1:0] za_q;
  logic                 neg_q;
  logic        [1:0]    quad_q;
  logic        [45:0]   phi_prod_q;
  logic signed [31:0]   ox_a_q, oy_a_q, oz_a_q, rho_a_q;

  always_ff @(posedge clk_i) begin
    za_q       <= za_d;
    neg_q      <= neg_d;
    quad_q     <= azimuth_angle_i[15:14];
    phi_prod_q <= phi_prod_d;
    ox_a_q     <= origin_x_i;
    oy_a_q     <= origin_y_i;
    oz_a_q     <= origin_z_i;
    rho_a_q    <= radius_i;
  end

  // CORDIC pipeline, one iteration per stage for both angles.
  logic [45:0] phi_sum;
  cstage_t     cs_init;

  always_comb begin
    phi_sum         = phi_prod_q + 46'd8192;
    cs_init.th.x    = GAIN_Q30;
    cs_init.th.y    = '0;
    cs_init.th.z    = za_q;
    cs_init.ph.x    = GAIN_Q30;
    cs_init.ph.y    = '0;
    cs_init.ph.z    = $signed({2'b00, phi_sum[45:14]});
    cs_init.neg_ct  = neg_q;
    cs_init.quad    = quad_q;
    cs_init.ox      = ox_a_q;
    cs_init.oy      = oy_a_q;
    cs_init.oz      = oz_a_q;
    cs_init.rho     = rho_a_q;
  end

  cstage_t cs_in [CORDIC_STEPS];
  cstage_t cs_d  [CORDIC_STEPS];
  cstage_t cs_q  [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    if (k == 0) begin : g_first
      assign cs_in[k] = cs_init;
    end else begin : g_next
      assign cs_in[k] = cs_q[k-1];
    end

    always_comb begin
      cs_d[k]    = cs_in[k];
      cs_d[k].th = cordic_step(cs_in[k].th, k);
      cs_d[k].ph = cordic_step(cs_in[k].ph, k);
    end

    always_ff @(posedge clk_i) begin
      cs_q[k] <= cs_d[k];
    end
  end

  // First product stage: radius times the polar sine and cosine.
  cstage_t              cl;
  logic signed [CW-1:0] ct, cp_d, sp_d;
  logic signed [65:0]   pt_d, py_d;

  always_comb begin
    cl = cs_q[CORDIC_STEPS-1];
    ct = cl.neg_ct ? -cl.th.x : cl.th.x;
    case (cl.quad)
      2'd0: begin
        cp_d = cl.ph.x;
        sp_d = cl.ph.y;
      end
      2'd1: begin
        cp_d = -cl.ph.y;
        sp_d = cl.ph.x;
      end
      2'd2: begin
        cp_d = -cl.ph.x;
        sp_d = -cl.ph.y;
      end
      default: begin
        cp_d = cl.ph.y;
        sp_d = -cl.ph.x;
      end
    endcase
    pt_d = 66'(cl.rho) * 66'(cl.th.y);
    py_d = 66'(cl.rho) * 66'(ct);
  end

  logic signed [65:0]   pt_q, py_q;
  logic signed [CW-1:0] cp_q1, sp_q1;
  logic signed [31:0]   ox_q1, oy_q1, oz_q1;

  always_ff @(posedge clk_i) begin
    pt_q  <= pt_d;
    py_q  <= py_d;
    cp_q1 <= cp_d;
    sp_q1 <= sp_d;
    ox_q1 <= cl.ox;
    oy_q1 <= cl.oy;
    oz_q1 <= cl.oz;
  end

  // Second stage: round the products and form the y sum.
  logic signed [65:0] pt_r, py_r;
  logic signed [35:0] t_d;
  logic signed [36:0] ysum_d;

  always_comb begin
    pt_r   = (pt_q + RND66) >>> 30;
    py_r   = (py_q + RND66) >>> 30;
    t_d    = pt_r[35:0];
    ysum_d = 37'(oy_q1) + 37'($signed(py_r[35:0]));
  end

  logic signed [35:0]   t_q;
  logic signed [36:0]   ysum_q2;
  logic signed [CW-1:0] cp_q2, sp_q2;
  logic signed [31:0]   ox_q2, oz_q2;

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    ysum_q2 <= ysum_d;
    cp_q2   <= cp_q1;
    sp_q2   <= sp_q1;
    ox_q2   <= ox_q1;
    oz_q2   <= oz_q1;
  end

  // Third stage: project onto the azimuth cosine and sine.
  logic signed [69:0] px_q, pz_q;
  logic signed [36:0] ysum_q3;
  logic signed [31:0] ox_q3, oz_q3;

  always_ff @(posedge clk_i) begin
    px_q    <= 70'(t_q) * 70'(cp_q2);
    pz_q    <= 70'(t_q) * 70'(sp_q2);
    ysum_q3 <= ysum_q2;
    ox_q3   <= ox_q2;
    oz_q3   <= oz_q2;
  end

  // Last stage: round, add the origin and saturate.
  logic signed [69:0] px_r, pz_r;
  sat_t               sx, sy, sz;

  always_comb begin
    px_r = (px_q + RND70) >>> 30;
    pz_r = (pz_q + RND70) >>> 30;
    sx   = saturate(41'(ox_q3) + 41'($signed(px_r[39:0])));
    sy   = saturate(41'(ysum_q3));
    sz   = saturate(41'(oz_q3) + 41'($signed(pz_r[39:0])));
  end

  logic [31:0] px_out_q, py_out_q, pz_out_q;
  logic        sat_out_q;

  always_ff @(posedge clk_i) begin
    px_out_q  <= sx.value;
    py_out_q  <= sy.value;
    pz_out_q  <= sz.value;
    sat_out_q <= sx.sat | sy.sat | sz.sat;
  end

  assign point_x_o   = px_out_q;
  assign point_y_o   = py_out_q;
  assign point_z_o   = pz_out_q;
  assign saturated_o = sat_out_q;

endmodule
